FILE: hdl/sfs_pkg.sv
// shared codes, widths and types of the sprite frame sequencer
package sfs_pkg;

	// fixed field widths
	localparam int PERIOD_W    = 24;
	localparam int DELTA_W     = 24;
	localparam int FRAME_IDX_W = 4;
	localparam int FRAME_CNT_W = 5;
	localparam int OP_W        = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PLAY  = 3'd1;
	localparam logic [OP_W-1:0] OP_PAUSE = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_END_ENABLE   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_END_FRAME    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LOOPED       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERT_X     = 3'd5;

	// configuration reset values
	localparam logic [PERIOD_W-1:0]    PERIOD_RESET = 24'd100000;
	localparam logic [FRAME_CNT_W-1:0] COUNT_RESET  = 5'd1;

	// status of the serial remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hdl/sfs_divider.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module sfs_divider #(
	parameter int DVD_W = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DVD_W-1:0]             dividend,
	input  logic [sfs_pkg::PERIOD_W-1:0] divisor,
	output logic [sfs_pkg::PERIOD_W-1:0] remainder,
	output sfs_pkg::div_stat_t           stat
);
	import sfs_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]    dvd_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic                fits;

	// shift in the next dividend bit and try one subtract
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	// remainder datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
		end
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DVD_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hdl/sfs_frame_table.sv
// frame rectangle memory, one write port and one registered read port
module sfs_frame_table #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 48
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/sprite_frame_sequencer_core.sv
// sprite animation frame sequencer: sequencer, frame table and remainder unit
//
// Input items arrive on in_valid / in_stall; a beat is taken when in_valid is
// high and in_stall low. Each item (tick, play, pause, stop or table load)
// gives exactly one result beat on out_valid / out_stall with the current
// frame, the play state and the texture coordinates of that frame.
// Configuration registers are written over cfg_valid / cfg_ready (always
// ready); the user must write them only while no item is in flight, as the
// block does not enforce it. An item runs from accept through the execute,
// read and emit states; a tick that is neither paused nor at the enabled end
// frame also passes the check state, and one that crosses a nonzero period
// then runs the serial remainder unit, one elapsed-time bit a cycle.
// Only one item is worked on at a time: in_stall stays high from the accept
// until the result is loaded into the output register. A new item may be
// taken while that result still waits on a stalled receiver; its own result
// then holds until the output register frees up.
// Reset leaves the sequencer paused on frame 0 with zero elapsed time and the
// registers at their reset values. The frame table is not cleared; an entry
// must be loaded before a result reads it.
module sprite_frame_sequencer_core #(
	parameter int MAX_FRAMES = 16,
	parameter int COORD_BITS = 12,
	parameter int TIME_BITS  = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sfs_pkg::OP_W-1:0]        operation,
	input  logic [sfs_pkg::DELTA_W-1:0]     delta_us,
	input  logic [sfs_pkg::FRAME_IDX_W-1:0] load_index,
	input  logic [COORD_BITS-1:0]           rect_left,
	input  logic [COORD_BITS-1:0]           rect_top,
	input  logic [COORD_BITS-1:0]           rect_width,
	input  logic [COORD_BITS-1:0]           rect_height,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sfs_pkg::FRAME_IDX_W-1:0] frame_index,
	output logic                            playing,
	output logic                            advanced,
	output logic [COORD_BITS:0]             tex_left,
	output logic [COORD_BITS:0]             tex_right,
	output logic [COORD_BITS-1:0]           tex_top,
	output logic [COORD_BITS:0]             tex_bottom,
	output logic [COORD_BITS-1:0]           quad_width,
	output logic [COORD_BITS-1:0]           quad_height
);
	import sfs_pkg::*;

	localparam int FW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CMPW   = (FW + 1 > FRAME_CNT_W) ? FW + 1 : FRAME_CNT_W;
	localparam int EQW    = (FW > FRAME_IDX_W) ? FW : FRAME_IDX_W;
	localparam int EL_W   = TIME_BITS + 1;
	localparam int TCMP_W = (EL_W > PERIOD_W) ? EL_W : PERIOD_W;
	localparam int DLT_W  = (TIME_BITS < DELTA_W) ? TIME_BITS : DELTA_W;
	localparam int ENT_W  = 4 * COORD_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CHECK,
		S_DIV,
		S_READ,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [PERIOD_W-1:0]    period_q;
	logic [FRAME_CNT_W-1:0] count_q;
	logic                   end_en_q;
	logic [FRAME_IDX_W-1:0] end_frame_q;
	logic                   looped_q;
	logic                   invert_q;

	// sequencer state
	logic [FW-1:0]          frame_q;
	logic [EL_W-1:0]        elapsed_q;
	logic                   paused_q;
	logic                   adv_q;

	// captured item
	logic [OP_W-1:0]        op_q;
	logic [DLT_W-1:0]       delta_q;
	logic [FRAME_IDX_W-1:0] load_idx_q;
	logic [ENT_W-1:0]       entry_q;

	// output register
	logic                   out_valid_q;
	logic [FRAME_IDX_W-1:0] frame_index_q;
	logic                   playing_q;
	logic                   advanced_q;
	logic [COORD_BITS:0]    tex_left_q;
	logic [COORD_BITS:0]    tex_right_q;
	logic [COORD_BITS-1:0]  tex_top_q;
	logic [COORD_BITS:0]    tex_bottom_q;
	logic [COORD_BITS-1:0]  quad_width_q;
	logic [COORD_BITS-1:0]  quad_height_q;

	logic                   in_beat;
	logic                   out_free;
	logic                   at_end;
	logic                   has_next;
	logic [CMPW-1:0]        cnt_eff;
	logic [EL_W-1:0]        sum;
	logic                   reached;
	logic                   load_ok;
	logic                   tbl_wr;
	logic                   tbl_rd;
	logic [ENT_W-1:0]       rd_data;
	logic                   div_start;
	logic [PERIOD_W-1:0]    div_rem;
	div_stat_t              div_stat;
	logic [COORD_BITS-1:0]  r_left;
	logic [COORD_BITS-1:0]  r_top;
	logic [COORD_BITS-1:0]  r_width;
	logic [COORD_BITS-1:0]  r_height;
	logic [COORD_BITS:0]    x_sum;
	logic [COORD_BITS:0]    y_sum;

	assign in_stall  = (state_q != S_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// frame advance decisions
	assign cnt_eff  = (CMPW'(count_q) > CMPW'(MAX_FRAMES)) ? CMPW'(MAX_FRAMES)
	                                                       : CMPW'(count_q);
	assign has_next = (CMPW'(frame_q) + CMPW'(1)) < cnt_eff;
	assign at_end   = end_en_q && (EQW'(end_frame_q) == EQW'(frame_q));
	assign sum      = elapsed_q + EL_W'(delta_q);
	assign reached  = TCMP_W'(elapsed_q) >= TCMP_W'(period_q);
	assign load_ok  = CMPW'(load_idx_q) < CMPW'(MAX_FRAMES);

	// table and remainder unit control
	assign tbl_wr    = (state_q == S_EXEC) && (op_q == OP_LOAD) && load_ok;
	assign tbl_rd    = (state_q == S_READ);
	assign div_start = (state_q == S_CHECK) && reached && (period_q != '0);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			count_q     <= COUNT_RESET;
			end_en_q    <= 1'b0;
			end_frame_q <= '0;
			looped_q    <= 1'b0;
			invert_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_PERIOD: period_q    <= cfg_data[PERIOD_W-1:0];
				REG_FRAME_COUNT:  count_q     <= cfg_data[FRAME_CNT_W-1:0];
				REG_END_ENABLE:   end_en_q    <= cfg_data[0];
				REG_END_FRAME:    end_frame_q <= cfg_data[FRAME_IDX_W-1:0];
				REG_LOOPED:       looped_q    <= cfg_data[0];
				REG_INVERT_X:     invert_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q       <= operation;
			delta_q    <= delta_us[DLT_W-1:0];
			load_idx_q <= load_index;
			entry_q    <= {rect_left, rect_top, rect_width, rect_height};
		end
	end

	// sequencer and play state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frame_q     <= '0;
			elapsed_q   <= '0;
			paused_q    <= 1'b1;
			adv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						adv_q   <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_READ;
					unique case (op_q)
						OP_TICK: begin
							if (!paused_q && !at_end) begin
								elapsed_q <= sum;
								state_q   <= S_CHECK;
							end
						end
						OP_PLAY:  paused_q <= 1'b0;
						OP_PAUSE: paused_q <= 1'b1;
						OP_STOP: begin
							paused_q  <= 1'b1;
							frame_q   <= '0;
							elapsed_q <= '0;
						end
						default: ;
					endcase
				end
				S_CHECK: begin
					state_q <= S_READ;
					if (reached) begin
						adv_q <= 1'b1;
						if (has_next) begin
							frame_q <= frame_q + 1'b1;
						end else if (looped_q) begin
							frame_q <= '0;
						end else begin
							paused_q <= 1'b1;
						end
						if (period_q == '0) begin
							elapsed_q <= '0;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						elapsed_q <= EL_W'(div_rem);
						state_q   <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// texture coordinates of the current frame
	assign {r_left, r_top, r_width, r_height} = rd_data;
	assign x_sum = {1'b0, r_left} + {1'b0, r_width};
	assign y_sum = {1'b0, r_top} + {1'b0, r_height};

	// result payload
	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			frame_index_q <= FRAME_IDX_W'(frame_q);
			playing_q     <= !paused_q;
			advanced_q    <= adv_q;
			tex_left_q    <= invert_q ? x_sum : {1'b0, r_left};
			tex_right_q   <= invert_q ? {1'b0, r_left} : x_sum;
			tex_top_q     <= r_top;
			tex_bottom_q  <= y_sum;
			quad_width_q  <= r_width;
			quad_height_q <= r_height;
		end
	end

	sfs_frame_table #(
		.DEPTH  (MAX_FRAMES),
		.ADDR_W (FW),
		.DATA_W (ENT_W)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (FW'(load_idx_q)),
		.wr_data (entry_q),
		.rd_en   (tbl_rd),
		.rd_addr (frame_q),
		.rd_data (rd_data)
	);

	sfs_divider #(
		.DVD_W (EL_W)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (elapsed_q),
		.divisor   (period_q),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	assign out_valid   = out_valid_q;
	assign frame_index = frame_index_q;
	assign playing     = playing_q;
	assign advanced    = advanced_q;
	assign tex_left    = tex_left_q;
	assign tex_right   = tex_right_q;
	assign tex_top     = tex_top_q;
	assign tex_bottom  = tex_bottom_q;
	assign quad_width  = quad_width_q;
	assign quad_height = quad_height_q;

endmodule
